// ----- rtl/usst_pkg.sv -----
// Package for the unique 64-bit value set table.
// Holds request/response structs, opcode and status codes, and the sequencer state type.
// No dependencies.
package usst_pkg;

    // Opcodes (any code other than insert or remove acts as a lookup)
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [4:0] slot_index;
        logic [4:0] used_count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_SHR_RD,
        S_SHR_CMP,
        S_DONE
    } t_state;

endpackage

// ----- rtl/unique_u64_set_table.sv -----
// Top level of the unique 64-bit value set table.
// Depends on usst_pkg (types, codes) and usst_ram (slot storage).
//
// Usage:
//   Request channel (i_in_valid / o_in_ready / i_in_req) carries one insert,
//   remove or lookup of a 64-bit value. Response channel (o_out_valid /
//   i_out_ready / o_out_rsp) returns one status/found/slot/count word per request.
//   The free-slot marker is written via i_cfg_we/i_cfg_wdata by the user only while idle (unchecked).
// Timing:
//   One request at a time. Shared 64-bit comparators walk the slot RAM one
//   slot per cycle. A miss walks every slot below the mark; a hit stops at its
//   slot. A slot write follows in S_WRITE, and lowering the mark examines slots
//   one by one, each in S_SHR_RD then S_SHR_CMP. A marker request goes straight
//   to S_DONE, which loads the response; the sequencer then returns to S_IDLE.
// Reset clears the mark, the marker and the sequencer; slot contents stay, as
// only slots below the mark are ever read.
// While the receiver stalls, a response waits in the output register; the next
// request is still accepted and its result holds in the sequencer until the
// register frees.
module unique_u64_set_table
    import usst_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out_rsp,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] CAP_IDX = IW'(CAPACITY);
    localparam logic [IW-1:0] ONE_IDX = IW'(1);

    // Control registers
    t_state          r_state, n_state;
    logic [IW-1:0]   r_hw, n_hw;
    logic            r_cmp_valid, n_cmp_valid;
    logic            r_out_valid, n_out_valid;
    logic [63:0]     r_empty;

    // Payload registers
    logic [1:0]      r_op, n_op;
    logic [63:0]     r_val, n_val;
    logic [IW-1:0]   r_rd_idx, n_rd_idx;
    logic [IW-1:0]   r_cmp_idx, n_cmp_idx;
    logic [IW-1:0]   r_avail, n_avail;
    logic [1:0]      r_status, n_status;
    logic            r_found, n_found;
    logic [IW-1:0]   r_slot, n_slot;
    t_rsp            r_out, n_out;

    // RAM port signals
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [63:0]     ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [63:0]     ram_rdata;

    logic            is_insert;
    logic            is_remove;
    logic            in_is_marker;
    logic            rd_is_hit;
    logic            rd_is_free;
    logic            issue;
    logic [IW-1:0]   hw_dec;

    usst_ram #(
        .WIDTH (64),
        .DEPTH (CAPACITY)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared comparators on the RAM read data
    assign rd_is_hit  = (ram_rdata == r_val);
    assign rd_is_free = (ram_rdata == r_empty);
    assign is_insert  = (r_op == OP_INSERT);
    assign is_remove  = (r_op == OP_REMOVE);
    assign in_is_marker = (i_in_req.value == r_empty);
    assign issue      = (r_rd_idx < r_hw);
    assign hw_dec     = r_hw - ONE_IDX;

    // Read address: walk pointer while scanning, top slot while shrinking
    always_comb begin
        if (r_state == S_SHR_RD) begin
            ram_raddr = hw_dec[AW-1:0];
        end else begin
            ram_raddr = r_rd_idx[AW-1:0];
        end
    end

    assign ram_waddr = r_slot[AW-1:0];
    assign ram_wdata = is_insert ? r_val : r_empty;
    assign ram_we    = (r_state == S_WRITE);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_hw        = r_hw;
        n_cmp_valid = r_cmp_valid;
        n_op        = r_op;
        n_val       = r_val;
        n_rd_idx    = r_rd_idx;
        n_cmp_idx   = r_cmp_idx;
        n_avail     = r_avail;
        n_status    = r_status;
        n_found     = r_found;
        n_slot      = r_slot;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // Drop the response once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op        = i_in_req.opcode;
                    n_val       = i_in_req.value;
                    n_rd_idx    = '0;
                    n_cmp_valid = 1'b0;
                    n_avail     = r_hw;
                    n_status    = ST_OK;
                    n_found     = 1'b0;
                    n_slot      = CAP_IDX;
                    if (in_is_marker) begin
                        // Marker is never stored: reject insert, report absent otherwise
                        if (i_in_req.opcode == OP_INSERT) begin
                            n_status = ST_INVAL;
                        end
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (r_cmp_valid && rd_is_hit) begin
                    // Stop at the first match
                    n_found     = 1'b1;
                    n_slot      = r_cmp_idx;
                    n_cmp_valid = 1'b0;
                    n_state     = is_remove ? S_WRITE : S_DONE;
                end else begin
                    // Track the lowest free slot
                    if (r_cmp_valid && rd_is_free && (r_avail == r_hw)) begin
                        n_avail = r_cmp_idx;
                    end
                    if (issue) begin
                        n_rd_idx    = r_rd_idx + ONE_IDX;
                        n_cmp_valid = 1'b1;
                        n_cmp_idx   = r_rd_idx;
                    end else begin
                        n_cmp_valid = 1'b0;
                        if (!r_cmp_valid) begin
                            // Walk finished without a match
                            if (is_insert) begin
                                if (r_avail < CAP_IDX) begin
                                    n_slot  = r_avail;
                                    n_state = S_WRITE;
                                end else begin
                                    n_status = ST_FULL;
                                    n_state  = S_DONE;
                                end
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                    end
                end
            end

            S_WRITE: begin
                n_state = S_DONE;
                if (is_insert) begin
                    if (r_slot == r_hw) begin
                        n_hw = r_hw + ONE_IDX;
                    end
                end else if ((r_slot + ONE_IDX) == r_hw) begin
                    // Top slot freed: lower the mark and trim trailing free slots
                    n_hw = r_slot;
                    if (r_slot != '0) begin
                        n_state = S_SHR_RD;
                    end
                end
            end

            S_SHR_RD: begin
                n_state = S_SHR_CMP;
            end

            S_SHR_CMP: begin
                if (rd_is_free) begin
                    n_hw    = hw_dec;
                    n_state = (hw_dec != '0) ? S_SHR_RD : S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out.status     = r_status;
                    n_out.found      = r_found;
                    n_out.slot_index = 5'(r_slot);
                    n_out.used_count = 5'(r_hw);
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hw        <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_empty     <= '0;
        end else begin
            r_state     <= n_state;
            r_hw        <= n_hw;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_empty <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_val     <= n_val;
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_avail   <= n_avail;
        r_status  <= n_status;
        r_found   <= n_found;
        r_slot    <= n_slot;
        r_out     <= n_out;
    end

endmodule

// ----- rtl/usst_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module usst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
